[design/lst_pkg.sv]
// Package for the 7-point Laplacian stencil block: codes, widths and sequencer states.
`default_nettype none
package lst_pkg;

	localparam int CX_W   = 6;
	localparam int CY_W   = 6;
	localparam int CZ_W   = 4;
	localparam int SX_W   = 7;
	localparam int SY_W   = 7;
	localparam int SZ_W   = 5;
	localparam int DIM_W  = 2;
	localparam int ROW_W  = 12;
	localparam int LIN_W  = 20;
	localparam int PLN_W  = 14;
	localparam int NB_W   = 3;
	localparam int ADDR_W = 4;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_BAD_COORD = 2'd1;
	localparam status_t STATUS_BAD_SIZE  = 2'd2;

	localparam logic [1:0] REG_DIMENSIONS = 2'd0;
	localparam logic [1:0] REG_SIZE_X     = 2'd1;
	localparam logic [1:0] REG_SIZE_Y     = 2'd2;
	localparam logic [1:0] REG_SIZE_Z     = 2'd3;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [NB_W-1:0] NB_CENTER = 3'd0;
	localparam logic [NB_W-1:0] NB_XM     = 3'd1;
	localparam logic [NB_W-1:0] NB_XP     = 3'd2;
	localparam logic [NB_W-1:0] NB_YM     = 3'd3;
	localparam logic [NB_W-1:0] NB_YP     = 3'd4;
	localparam logic [NB_W-1:0] NB_ZM     = 3'd5;
	localparam logic [NB_W-1:0] NB_ZP     = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_CENTER,
		S_WRITE,
		S_READ,
		S_FINISH,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

[design/lst_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module lst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[design/laplacian_stencil_3d.sv]
// Top level of the 7-point discrete Laplacian block over a stored 1D/2D/3D grid.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  input   | in        | in_valid / in_stall        | mode coord_x coord_y coord_z sample
//  output  | out       | out_valid / out_stall      | laplacian status
//  config  | in        | psel penable pwrite pready | paddr pwdata prdata
//
// A query runs S_ROW, S_CENTER, S_READ, S_FINISH, S_DONE; a load S_ROW, S_CENTER,
// S_WRITE, S_DONE; an error S_DONE. S_READ reads the single-port RAM once per point.
// The block takes one request at a time; in_stall is high until it returns to idle.
// The output register frees the block while a result waits on out_stall.
// Reset presets config registers and sequencer; the grid is garbage until loaded.
`default_nettype none
module laplacian_stencil_3d
	import lst_pkg::*;
#(
	parameter int MAX_X        = 64,
	parameter int MAX_Y        = 64,
	parameter int MAX_Z        = 16,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ADDR_W-1:0]              paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           mode,
	input  wire logic [CX_W-1:0]                coord_x,
	input  wire logic [CY_W-1:0]                coord_y,
	input  wire logic [CZ_W-1:0]                coord_z,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH+3:0]      laplacian,
	output status_t                             status
);

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = SAMPLE_WIDTH + 4;

	function automatic logic [CX_W-1:0] clamp_xy(input logic [CX_W-1:0] p,
		input logic [SX_W-1:0] sz);
		logic [SX_W-1:0] hi;
		logic [CX_W-1:0] r;
		hi = sz - SX_W'(2);
		r  = p;
		if (SX_W'(p) > hi) begin
			r = hi[CX_W-1:0];
		end
		if (r == '0) begin
			r = CX_W'(1);
		end
		return r;
	endfunction

	function automatic logic [CZ_W-1:0] clamp_z(input logic [CZ_W-1:0] p,
		input logic [SZ_W-1:0] sz);
		logic [SZ_W-1:0] hi;
		logic [CZ_W-1:0] r;
		hi = sz - SZ_W'(2);
		r  = p;
		if (SZ_W'(p) > hi) begin
			r = hi[CZ_W-1:0];
		end
		if (r == '0) begin
			r = CZ_W'(1);
		end
		return r;
	endfunction

	// configuration registers
	logic [DIM_W-1:0] dimensions_q;
	logic [SX_W-1:0]  size_x_q;
	logic [SY_W-1:0]  size_y_q;
	logic [SZ_W-1:0]  size_z_q;
	logic             cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q <= DIM_W'(1);
			size_x_q     <= SX_W'(3);
			size_y_q     <= SY_W'(3);
			size_z_q     <= SZ_W'(3);
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_DIMENSIONS: dimensions_q <= pwdata[DIM_W-1:0];
				REG_SIZE_X:     size_x_q     <= pwdata[SX_W-1:0];
				REG_SIZE_Y:     size_y_q     <= pwdata[SY_W-1:0];
				REG_SIZE_Z:     size_z_q     <= pwdata[SZ_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIMENSIONS: prdata = 32'(dimensions_q);
			REG_SIZE_X:     prdata = 32'(size_x_q);
			REG_SIZE_Y:     prdata = 32'(size_y_q);
			REG_SIZE_Z:     prdata = 32'(size_z_q);
			default:        prdata = '0;
		endcase
	end

	// request decode
	logic [DIM_W-1:0] dims_eff;
	logic             use_y;
	logic             use_z;
	logic             size_bad;
	logic             coord_bad;
	status_t          status_d;
	logic [CX_W-1:0]  i_d;
	logic [CY_W-1:0]  j_d;
	logic [CZ_W-1:0]  k_d;

	assign dims_eff = (dimensions_q == '0) ? DIM_W'(1) : dimensions_q;
	assign use_y    = dims_eff >= DIM_W'(2);
	assign use_z    = dims_eff == DIM_W'(3);

	always_comb begin
		size_bad = (size_x_q < SX_W'(3)) || (32'(size_x_q) > 32'(MAX_X)) ||
			(use_y && ((size_y_q < SY_W'(3)) || (32'(size_y_q) > 32'(MAX_Y)))) ||
			(use_z && ((size_z_q < SZ_W'(3)) || (32'(size_z_q) > 32'(MAX_Z))));
		coord_bad = (SX_W'(coord_x) >= size_x_q) ||
			(use_y && (SY_W'(coord_y) >= size_y_q)) ||
			(use_z && (SZ_W'(coord_z) >= size_z_q));
		if (size_bad) begin
			status_d = STATUS_BAD_SIZE;
		end else if (coord_bad) begin
			status_d = STATUS_BAD_COORD;
		end else begin
			status_d = STATUS_OK;
		end
		if (mode == MODE_QUERY) begin
			i_d = clamp_xy(coord_x, size_x_q);
			j_d = use_y ? clamp_xy(coord_y, size_y_q) : '0;
			k_d = use_z ? clamp_z(coord_z, size_z_q) : '0;
		end else begin
			i_d = coord_x;
			j_d = use_y ? coord_y : '0;
			k_d = use_z ? coord_z : '0;
		end
	end

	// sequencer
	state_t                   state_q, state_d;
	logic                     in_take;
	logic                     out_load;
	logic                     ram_we;
	logic [NB_W-1:0]          cnt_q;
	logic [NB_W-1:0]          nb_last;
	logic                     mode_q;
	status_t                  status_q;
	logic [CX_W-1:0]          i_q;
	logic [CY_W-1:0]          j_q;
	logic [CZ_W-1:0]          k_q;
	logic [SAMPLE_WIDTH-1:0]  sample_q;
	logic [ROW_W-1:0]         row_q;
	logic [AW-1:0]            plane_q;
	logic [AW-1:0]            center_q;
	logic signed [LW-1:0]     acc_q;
	logic                     rd_valid_s1;
	logic [NB_W-1:0]          rd_idx_s1;

	assign nb_last  = NB_W'({dims_eff, 1'b0});
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ram_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					state_d = (status_d == STATUS_OK) ? S_ROW : S_DONE;
				end
			end
			S_ROW: state_d = S_CENTER;
			S_CENTER: state_d = (mode_q == MODE_LOAD) ? S_WRITE : S_READ;
			S_WRITE: begin
				ram_we  = 1'b1;
				state_d = S_DONE;
			end
			S_READ: begin
				if (cnt_q == nb_last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// shared address adder: center plus or minus one stride
	logic [AW-1:0] stride;
	logic          stride_sub;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] ram_addr;

	always_comb begin
		case (cnt_q)
			NB_XM, NB_XP: stride = AW'(1);
			NB_YM, NB_YP: stride = AW'(size_x_q);
			NB_ZM, NB_ZP: stride = plane_q;
			default:      stride = '0;
		endcase
		stride_sub = (cnt_q == NB_XM) || (cnt_q == NB_YM) || (cnt_q == NB_ZM);
		rd_addr    = stride_sub ? (center_q - stride) : (center_q + stride);
		ram_addr   = ram_we ? center_q : rd_addr;
	end

	logic [SAMPLE_WIDTH-1:0] rd_data;

	lst_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample_q),
		.rdata(rd_data)
	);

	// accumulate
	logic signed [LW-1:0] rd_ext;
	logic signed [LW-1:0] center_term;

	assign rd_ext = LW'($signed(rd_data));

	always_comb begin
		case (dims_eff)
			DIM_W'(2): center_term = -(rd_ext <<< 2);
			DIM_W'(3): center_term = -((rd_ext <<< 1) + (rd_ext <<< 2));
			default:   center_term = -(rd_ext <<< 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			rd_valid_s1 <= (state_q == S_READ);
			rd_idx_s1   <= cnt_q;
			if (state_q == S_CENTER) begin
				cnt_q <= NB_CENTER;
			end else if (state_q == S_READ) begin
				cnt_q <= cnt_q + NB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q   <= mode;
			status_q <= status_d;
			i_q      <= i_d;
			j_q      <= j_d;
			k_q      <= k_d;
			sample_q <= sample;
			acc_q    <= '0;
		end
		if (state_q == S_ROW) begin
			row_q   <= ROW_W'(j_q) + ROW_W'(size_y_q) * ROW_W'(k_q);
			plane_q <= AW'(PLN_W'(size_x_q) * PLN_W'(size_y_q));
		end
		if (state_q == S_CENTER) begin
			center_q <= AW'(LIN_W'(i_q) + LIN_W'(size_x_q) * LIN_W'(row_q));
		end
		if (rd_valid_s1) begin
			if (rd_idx_s1 == NB_CENTER) begin
				acc_q <= center_term;
			end else begin
				acc_q <= acc_q + rd_ext;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			laplacian <= acc_q;
			status    <= status_q;
		end
	end

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("request accepted but block not busy next cycle");

	a_write_only_ok_load: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (mode_q == MODE_LOAD && status_q == STATUS_OK))
		else $error("grid written for a query or a failed load");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_OK) |-> (laplacian == '0))
		else $error("error result carries a nonzero laplacian");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (cnt_q <= nb_last))
		else $error("stencil read index past last neighbor");

endmodule
`default_nettype wire

[sim/tb_laplacian_stencil_3d.sv]
// Testbench for laplacian_stencil_3d: grid loads and stencil queries checked by a scoreboard.
import lst_pkg::*;

typedef struct packed {
	logic [CX_W-1:0] x;
	logic [CY_W-1:0] y;
	logic [CZ_W-1:0] z;
} grid_point_t;

class stencil_scoreboard;
	typedef struct packed {
		logic signed [35:0] lap;
		status_t            st;
	} lap_result_t;

	logic [DIM_W-1:0]   dims   = 2'd1;
	logic [SX_W-1:0]    size_x = 7'd3;
	logic [SY_W-1:0]    size_y = 7'd3;
	logic [SZ_W-1:0]    size_z = 5'd3;
	logic signed [31:0] grid[int];
	lap_result_t        pending[$];
	int                 errors;

	function void set_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_DIMENSIONS: dims = data[DIM_W-1:0];
			REG_SIZE_X:     size_x = data[SX_W-1:0];
			REG_SIZE_Y:     size_y = data[SY_W-1:0];
			REG_SIZE_Z:     size_z = data[SZ_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [31:0] reg_value(logic [1:0] idx);
		case (idx)
			REG_DIMENSIONS: return 32'(dims);
			REG_SIZE_X:     return 32'(size_x);
			REG_SIZE_Y:     return 32'(size_y);
			default:        return 32'(size_z);
		endcase
	endfunction

	function int axes();
		return (dims == 0) ? 1 : int'(dims);
	endfunction

	function status_t status_of(grid_point_t p);
		int n;
		n = axes();
		if (size_x < 3 || size_x > 64 || (n >= 2 && (size_y < 3 || size_y > 64)) ||
		    (n >= 3 && (size_z < 3 || size_z > 16)))
			return STATUS_BAD_SIZE;
		if (p.x >= size_x || (n >= 2 && p.y >= size_y) || (n >= 3 && p.z >= size_z))
			return STATUS_BAD_COORD;
		return STATUS_OK;
	endfunction

	function int addr_of(grid_point_t p);
		int yy;
		int zz;
		yy = (axes() >= 2) ? int'(p.y) : 0;
		zz = (axes() >= 3) ? int'(p.z) : 0;
		return int'(p.x) + int'(size_x) * (yy + int'(size_y) * zz);
	endfunction

	function int clamp(int p, int size);
		if (p > size - 2)
			p = size - 2;
		if (p < 1)
			p = 1;
		return p;
	endfunction

	// center first, then the neighbor pairs of each used axis
	function void stencil(grid_point_t p, output grid_point_t pts[$]);
		grid_point_t c;
		grid_point_t q;
		int n;
		n = axes();
		pts.delete();
		c.x = CX_W'(clamp(int'(p.x), int'(size_x)));
		c.y = (n >= 2) ? CY_W'(clamp(int'(p.y), int'(size_y))) : '0;
		c.z = (n >= 3) ? CZ_W'(clamp(int'(p.z), int'(size_z))) : '0;
		pts.push_back(c);
		for (int a = 0; a < n; a++) begin
			for (int d = -1; d <= 1; d += 2) begin
				q = c;
				case (a)
					0: q.x = CX_W'(int'(c.x) + d);
					1: q.y = CY_W'(int'(c.y) + d);
					default: q.z = CZ_W'(int'(c.z) + d);
				endcase
				pts.push_back(q);
			end
		end
	endfunction

	function bit loaded(grid_point_t p);
		return grid.exists(addr_of(p));
	endfunction

	function bit stencil_loaded(grid_point_t p);
		grid_point_t pts[$];
		stencil(p, pts);
		foreach (pts[i])
			if (!loaded(pts[i]))
				return 1'b0;
		return 1'b1;
	endfunction

	function void note_request(logic m, grid_point_t p, logic signed [31:0] s);
		lap_result_t r;
		grid_point_t pts[$];
		longint      acc;
		r.lap = '0;
		r.st  = status_of(p);
		if (r.st == STATUS_OK) begin
			if (m == MODE_LOAD) begin
				grid[addr_of(p)] = s;
			end else begin
				stencil(p, pts);
				acc = 0;
				for (int i = 1; i < pts.size(); i++)
					acc += longint'(grid[addr_of(pts[i])]);
				acc -= longint'(pts.size() - 1) * longint'(grid[addr_of(pts[0])]);
				r.lap = 36'(acc);
			end
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic signed [35:0] lap, status_t st);
		lap_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result laplacian %0d status %0d", $time, lap, st);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (lap !== e.lap) begin
			$display("%0t: laplacian expected %0d got %0d", $time, e.lap, lap);
			errors++;
		end
		if (st !== e.st) begin
			$display("%0t: status expected %0d got %0d", $time, e.st, st);
			errors++;
		end
	endfunction
endclass

module tb_laplacian_stencil_3d;
	localparam int WATCH_LIMIT = 1000;

	logic                     clk;
	logic                     arst_n   = 1'b0;
	logic                     psel     = 1'b0;
	logic                     penable  = 1'b0;
	logic                     pwrite   = 1'b0;
	logic [ADDR_W-1:0]        paddr    = '0;
	logic [31:0]              pwdata   = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     mode     = MODE_LOAD;
	logic [CX_W-1:0]          coord_x  = '0;
	logic [CY_W-1:0]          coord_y  = '0;
	logic [CZ_W-1:0]          coord_z  = '0;
	logic signed [31:0]       sample   = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [35:0]       laplacian;
	status_t                  status;

	stencil_scoreboard sb = new;
	bit                calm;
	int                cfg_errors;
	int                items_sent;
	int                stall_left;
	int                idle_cycles;

	laplacian_stencil_3d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.coord_z   (coord_z),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.laplacian (laplacian),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(laplacian, status);
			stall_left = calm ? 0 : $urandom_range(0, 15);
			out_stall <= (stall_left != 0);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCH_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [31:0] random_sample();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic grid_point_t make_point(int x, int y, int z);
		grid_point_t p;
		p.x = CX_W'(x);
		p.y = CY_W'(y);
		p.z = CZ_W'(z);
		return p;
	endfunction

	task automatic send_item(logic m, grid_point_t p, logic signed [31:0] s);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		coord_x  <= p.x;
		coord_y  <= p.y;
		coord_z  <= p.z;
		sample   <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(m, p, s);
		items_sent++;
	endtask

	// hold off new requests until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, data);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== sb.reg_value(idx)) begin
			$display("%0t: register %0d expected %0d got %0d", $time, idx, sb.reg_value(idx), got);
			cfg_errors++;
		end
	endtask

	function automatic logic [31:0] junk(int w);
		return ($urandom_range(0, 1) != 0) ? ($urandom << w) : 32'd0;
	endfunction

	task automatic configure(logic [1:0] d, logic [6:0] sx, logic [6:0] sy, logic [4:0] sz);
		drain();
		reg_write(REG_DIMENSIONS, junk(DIM_W) | 32'(d));
		reg_write(REG_SIZE_X, junk(SX_W) | 32'(sx));
		reg_write(REG_SIZE_Y, junk(SY_W) | 32'(sy));
		reg_write(REG_SIZE_Z, junk(SZ_W) | 32'(sz));
		calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic random_phase(int n);
		int          start;
		logic        m;
		grid_point_t p;
		grid_point_t pts[$];
		start = items_sent;
		while (items_sent - start < n) begin
			p = make_point($urandom, $urandom, $urandom);
			m = 1'($urandom_range(0, 1));
			if (sb.status_of(p) == STATUS_BAD_SIZE || $urandom_range(0, 9) == 0) begin
				if (m == MODE_QUERY && sb.status_of(p) == STATUS_OK && !sb.stencil_loaded(p))
					m = MODE_LOAD;
				send_item(m, p, random_sample());
			end else begin
				p.x = CX_W'($urandom_range(0, sb.size_x - 1));
				if (sb.axes() >= 2)
					p.y = CY_W'($urandom_range(0, sb.size_y - 1));
				if (sb.axes() >= 3)
					p.z = CZ_W'($urandom_range(0, sb.size_z - 1));
				if ($urandom_range(0, 9) < 4) begin
					send_item(MODE_LOAD, p, random_sample());
				end else begin
					sb.stencil(p, pts);
					foreach (pts[i])
						if (!sb.loaded(pts[i]))
							send_item(MODE_LOAD, pts[i], random_sample());
					send_item(MODE_QUERY, p, random_sample());
				end
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_LOAD, make_point(0, 63, 15), 32'sh7fff_ffff);
		send_item(MODE_LOAD, make_point(1, 0, 0), 32'sh8000_0000);
		send_item(MODE_LOAD, make_point(2, 21, 10), 32'sh7fff_ffff);
		send_item(MODE_QUERY, make_point(0, 63, 15), '0);
		send_item(MODE_QUERY, make_point(2, 0, 0), 32'sh7fff_ffff);
		send_item(MODE_QUERY, make_point(1, 42, 5), '0);
		send_item(MODE_QUERY, make_point(63, 0, 0), '0);
		send_item(MODE_LOAD, make_point(3, 0, 0), 32'sh5555_5555);
		send_item(MODE_QUERY, make_point(1, 0, 0), '0);
		send_item(MODE_LOAD, make_point(1, 63, 15), -32'sd1);
		send_item(MODE_QUERY, make_point(2, 63, 15), '0);

		configure(2'd0, 7'd64, 7'd3, 5'd3);
		random_phase(70);
		configure(2'd2, 7'd5, 7'd4, 5'd3);
		random_phase(90);
		configure(2'd3, 7'd3, 7'd3, 5'd3);
		random_phase(70);
		configure(2'd1, 7'd2, 7'd9, 5'd3);
		random_phase(15);
		configure(2'd3, 7'd6, 7'd5, 5'd4);
		calm = 1'b1;
		random_phase(100);
		configure(2'd2, 7'd64, 7'd64, 5'd0);
		random_phase(120);
		configure(2'd2, 7'd8, 7'd65, 5'd3);
		random_phase(15);
		configure(2'd3, 7'd64, 7'd64, 5'd16);
		random_phase(150);
		configure(2'd3, 7'd10, 7'd3, 5'd17);
		random_phase(15);
		configure(2'd3, 7'd127, 7'd0, 5'd31);
		random_phase(10);
		configure(2'd3, 7'd3, 7'd64, 5'd16);
		random_phase(80);
		configure(2'd1, 7'd64, 7'd127, 5'd31);
		random_phase(60);
		configure(2'd0, 7'd0, 7'd3, 5'd3);
		random_phase(15);
		repeat (4) begin
			configure(2'($urandom_range(1, 3)), 7'($urandom_range(3, 12)),
			          7'($urandom_range(3, 12)), 5'($urandom_range(3, 16)));
			random_phase(40);
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && cfg_errors == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

[files.f]
design/lst_pkg.sv
design/lst_ram.sv
design/laplacian_stencil_3d.sv
sim/tb_laplacian_stencil_3d.sv
